[sv/bgcs_pkg.sv]
`default_nettype none
package bgcs_pkg;

  localparam int unsigned AdcW   = 12;
  localparam int unsigned MvW    = 13;
  localparam int unsigned LvlW   = 3;
  localparam int unsigned DutyW  = 7;
  localparam int unsigned CntW   = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned QDepth = 2;

  localparam logic [MvW-1:0] FullScaleMv = 13'd5000;

  localparam logic [LvlW-1:0] LvlLow  = 3'd0;
  localparam logic [LvlW-1:0] Lvl10   = 3'd1;
  localparam logic [LvlW-1:0] Lvl25   = 3'd2;
  localparam logic [LvlW-1:0] Lvl50   = 3'd3;
  localparam logic [LvlW-1:0] Lvl75   = 3'd4;
  localparam logic [LvlW-1:0] LvlFull = 3'd5;
  localparam logic [LvlW-1:0] LvlOver = 3'd6;

  localparam logic ActInit = 1'b0;
  localparam logic ActTick = 1'b1;

  localparam logic [1:0] WsOff       = 2'd0;
  localparam logic [1:0] WsCharge    = 2'd1;
  localparam logic [1:0] WsChargeDis = 2'd2;
  localparam logic [1:0] WsDischarge = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgOver = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgFull = 3'd1;
  localparam logic [CfgIdxW-1:0] Cfg75   = 3'd2;
  localparam logic [CfgIdxW-1:0] Cfg50   = 3'd3;
  localparam logic [CfgIdxW-1:0] Cfg25   = 3'd4;
  localparam logic [CfgIdxW-1:0] Cfg10   = 3'd5;

  typedef struct packed {
    logic            action;
    logic            dc_in;
    logic [1:0]      work_state;
    logic [LvlW-1:0] cls;
  } bgcs_item_t;

  typedef struct packed {
    logic [LvlW-1:0]  level;
    logic             level_changed;
    logic [DutyW-1:0] pwm_duty;
    logic             low_flag;
    logic             full_flag;
    logic             over_flag;
    logic             info_high;
    logic [CntW-1:0]  low_entries;
    logic             warn_restart;
  } bgcs_result_t;

endpackage
`default_nettype wire

[sv/battery_gauge_charge_state.sv]
// Each input transfer is written to a queue slot; its result is then held in the output register.
// Throughput: one item per cycle while the queue has room; a two-entry queue separates
// classify and update. The output register holds a result while the consumer stalls;
// input keeps flowing until the queue fills.
// Reset (rst_ni low, async): thresholds to defaults, all gauge state and flags to zero.
`default_nettype none
module battery_gauge_charge_state (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [bgcs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [bgcs_pkg::MvW-1:0]     cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         action_i,
  input  wire logic                         dc_in_i,
  input  wire logic [1:0]                   work_state_i,
  input  wire logic [bgcs_pkg::AdcW-1:0]    adc_code_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [bgcs_pkg::LvlW-1:0]         level_o,
  output logic                              level_changed_o,
  output logic [bgcs_pkg::DutyW-1:0]        pwm_duty_o,
  output logic                              low_flag_o,
  output logic                              full_flag_o,
  output logic                              over_flag_o,
  output logic                              info_high_o,
  output logic [bgcs_pkg::CntW-1:0]         low_entries_o,
  output logic                              warn_restart_o
);

  bgcs_pkg::bgcs_item_t   front_item, q_item;
  bgcs_pkg::bgcs_result_t result;
  logic q_full, q_empty, q_pop;

  bgcs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .action_i     (action_i),
    .dc_in_i      (dc_in_i),
    .work_state_i (work_state_i),
    .adc_code_i   (adc_code_i),
    .item_o       (front_item)
  );

  assign in_ready_o = !q_full;

  bgcs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i && in_ready_o),
    .push_data_i (front_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_item),
    .empty_o     (q_empty)
  );

  bgcs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!q_empty),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result)
  );

  assign level_o         = result.level;
  assign level_changed_o = result.level_changed;
  assign pwm_duty_o      = result.pwm_duty;
  assign low_flag_o      = result.low_flag;
  assign full_flag_o     = result.full_flag;
  assign over_flag_o     = result.over_flag;
  assign info_high_o     = result.info_high;
  assign low_entries_o   = result.low_entries;
  assign warn_restart_o  = result.warn_restart;

endmodule
`default_nettype wire

[sv/bgcs_front.sv]
`default_nettype none
module bgcs_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [bgcs_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [bgcs_pkg::MvW-1:0]        cfg_wdata_i,
  input  wire logic                            action_i,
  input  wire logic                            dc_in_i,
  input  wire logic [1:0]                      work_state_i,
  input  wire logic [bgcs_pkg::AdcW-1:0]       adc_code_i,
  output bgcs_pkg::bgcs_item_t                 item_o
);

  logic [bgcs_pkg::MvW-1:0] over_q, full_q, l75_q, l50_q, l25_q, l10_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      over_q <= 13'd4250;
      full_q <= 13'd4100;
      l75_q  <= 13'd3900;
      l50_q  <= 13'd3750;
      l25_q  <= 13'd3600;
      l10_q  <= 13'd3400;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bgcs_pkg::CfgOver: over_q <= cfg_wdata_i;
        bgcs_pkg::CfgFull: full_q <= cfg_wdata_i;
        bgcs_pkg::Cfg75:   l75_q  <= cfg_wdata_i;
        bgcs_pkg::Cfg50:   l50_q  <= cfg_wdata_i;
        bgcs_pkg::Cfg25:   l25_q  <= cfg_wdata_i;
        bgcs_pkg::Cfg10:   l10_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [bgcs_pkg::AdcW+bgcs_pkg::MvW-1:0] prod;
  logic [bgcs_pkg::MvW-1:0]                mv;
  logic [bgcs_pkg::LvlW-1:0]               cls;

  assign prod = {{bgcs_pkg::MvW{1'b0}}, adc_code_i} *
                {{bgcs_pkg::AdcW{1'b0}}, bgcs_pkg::FullScaleMv};
  assign mv   = prod[bgcs_pkg::AdcW +: bgcs_pkg::MvW];

  always_comb begin
    if (mv >= over_q)     cls = bgcs_pkg::LvlOver;
    else if (mv > full_q) cls = bgcs_pkg::LvlFull;
    else if (mv > l75_q)  cls = bgcs_pkg::Lvl75;
    else if (mv > l50_q)  cls = bgcs_pkg::Lvl50;
    else if (mv > l25_q)  cls = bgcs_pkg::Lvl25;
    else if (mv > l10_q)  cls = bgcs_pkg::Lvl10;
    else                  cls = bgcs_pkg::LvlLow;
  end

  assign item_o.action     = action_i;
  assign item_o.dc_in      = dc_in_i;
  assign item_o.work_state = work_state_i;
  assign item_o.cls        = cls;

endmodule
`default_nettype wire

[sv/bgcs_queue.sv]
`default_nettype none
module bgcs_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire bgcs_pkg::bgcs_item_t push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output bgcs_pkg::bgcs_item_t pop_data_o,
  output logic                empty_o
);

  bgcs_pkg::bgcs_item_t mem_q [bgcs_pkg::QDepth];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = (count_q == 2'(bgcs_pkg::QDepth));
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(bgcs_pkg::QDepth)) else $error("queue overfilled");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("pop from empty queue");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers out of step");

endmodule
`default_nettype wire

[sv/bgcs_back.sv]
`default_nettype none
module bgcs_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            item_valid_i,
  input  wire bgcs_pkg::bgcs_item_t item_i,
  output logic                 item_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output bgcs_pkg::bgcs_result_t result_o
);

  logic [bgcs_pkg::LvlW-1:0]  shown_q, shown_d;
  logic                       low_q, low_d, full_q, full_d, over_q, over_d;
  logic                       info_q, info_d;
  logic [bgcs_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [bgcs_pkg::DutyW-1:0] duty_q, duty_d;
  logic                       changed, restart;
  logic [bgcs_pkg::LvlW-1:0]  tgt, step;
  logic                       out_valid_q;
  bgcs_pkg::bgcs_result_t     out_q, res;

  function automatic logic [bgcs_pkg::DutyW-1:0] pick_duty(
    input logic [1:0] ws, input logic [bgcs_pkg::LvlW-1:0] lvl);
    logic [bgcs_pkg::DutyW-1:0] d;
    d = 7'd0;
    if (ws == bgcs_pkg::WsCharge) begin
      case (lvl)
        bgcs_pkg::Lvl10: d = 7'd40;
        bgcs_pkg::Lvl25: d = 7'd70;
        bgcs_pkg::Lvl50: d = 7'd85;
        bgcs_pkg::Lvl75, bgcs_pkg::LvlFull: d = 7'd100;
        default: d = 7'd0;
      endcase
    end else if (ws == bgcs_pkg::WsChargeDis) begin
      d = 7'd100;
    end
    return d;
  endfunction

  function automatic logic [bgcs_pkg::CntW-1:0] sat_inc(input logic [bgcs_pkg::CntW-1:0] c);
    return (c < 2'd2) ? c + 2'd1 : c;
  endfunction

  assign item_pop_o  = item_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  always_comb begin
    shown_d = shown_q;
    low_d   = low_q;
    full_d  = full_q;
    over_d  = over_q;
    info_d  = info_q;
    cnt_d   = cnt_q;
    duty_d  = duty_q;
    changed = 1'b0;
    restart = 1'b0;
    tgt     = item_i.cls;
    step    = shown_q;
    if (item_i.action == bgcs_pkg::ActInit) begin
      shown_d = (item_i.cls >= bgcs_pkg::LvlFull) ? bgcs_pkg::Lvl75 : item_i.cls;
      if (shown_d == bgcs_pkg::LvlLow) begin
        low_d  = 1'b1;
        info_d = 1'b1;
        cnt_d  = sat_inc(cnt_q);
      end else begin
        low_d  = 1'b0;
        info_d = 1'b0;
      end
      restart = 1'b1;
    end else if (item_i.work_state != bgcs_pkg::WsOff) begin
      if (item_i.dc_in) begin
        if (over_q) begin
          if (item_i.cls < bgcs_pkg::LvlFull) begin
            over_d  = 1'b0;
            shown_d = bgcs_pkg::LvlFull;
            duty_d  = 7'd100;
          end
        end else begin
          if (full_q) begin
            if (tgt < bgcs_pkg::LvlFull) tgt = bgcs_pkg::LvlFull;
          end else if (tgt < bgcs_pkg::Lvl10) begin
            tgt = bgcs_pkg::Lvl10;
          end
          if (tgt > shown_q) begin
            step    = shown_q + 3'd1;
            shown_d = step;
            changed = 1'b1;
            if (step == bgcs_pkg::LvlOver) begin
              full_d = 1'b1;
              over_d = 1'b1;
            end else if (step == bgcs_pkg::LvlFull) begin
              full_d = 1'b1;
            end
            duty_d = pick_duty(item_i.work_state, step);
          end
        end
      end else begin
        if (tgt > bgcs_pkg::Lvl75) tgt = bgcs_pkg::Lvl75;
        if (tgt < shown_q) begin
          step    = shown_q - 3'd1;
          shown_d = step;
          changed = 1'b1;
          if (step == bgcs_pkg::LvlLow && !low_q) begin
            low_d   = 1'b1;
            cnt_d   = sat_inc(cnt_q);
            restart = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    res.level         = shown_d;
    res.level_changed = changed;
    res.pwm_duty      = duty_d;
    res.low_flag      = low_d;
    res.full_flag     = full_d;
    res.over_flag     = over_d;
    res.info_high     = info_d;
    res.low_entries   = cnt_d;
    res.warn_restart  = restart;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shown_q     <= bgcs_pkg::LvlLow;
      low_q       <= 1'b0;
      full_q      <= 1'b0;
      over_q      <= 1'b0;
      info_q      <= 1'b0;
      cnt_q       <= 2'd0;
      duty_q      <= 7'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_pop_o) begin
        shown_q <= shown_d;
        low_q   <= low_d;
        full_q  <= full_d;
        over_q  <= over_d;
        info_q  <= info_d;
        cnt_q   <= cnt_d;
        duty_q  <= duty_d;
      end
      if (item_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      out_q <= res;
    end
  end

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> ($stable(shown_q) && $stable(cnt_q)))
    else $error("state moved during output stall");
  a_out_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.level == shown_q && out_q.low_entries == cnt_q))
    else $error("output register out of step with state");
  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("low entry count past saturation");
  a_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    over_q |-> full_q) else $error("lockout without full mark");

endmodule
`default_nettype wire
